/* sv/mbap_pkg.sv */
// Shared types and constants for the MBAP frame codec.
// Holds item, result and queue-entry structs plus kind and operation codes.
// No dependencies.
package mbap_pkg;

	localparam logic [1:0] OP_RX_BYTE  = 2'd0;
	localparam logic [1:0] OP_TX_START = 2'd1;
	localparam logic [1:0] OP_TX_BYTE  = 2'd2;

	localparam logic [2:0] KIND_RX_START   = 3'd0;
	localparam logic [2:0] KIND_RX_PAYLOAD = 3'd1;
	localparam logic [2:0] KIND_BAD_PROTO  = 3'd2;
	localparam logic [2:0] KIND_BAD_LENGTH = 3'd3;
	localparam logic [2:0] KIND_TX_BYTE    = 3'd4;

	localparam logic [7:0] MAX_TX_PAYLOAD = 8'd252;
	localparam logic [3:0] HDR_BYTES      = 4'd8;
	localparam logic [2:0] TX_HDR_LAST    = 3'd7;
	localparam int         QUEUE_DEPTH    = 4;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic [7:0] unit_id;
		logic [7:0] function_code;
		logic [7:0] payload_size;
	} req_beat_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] out_byte;
		logic [7:0] frame_unit;
		logic [7:0] frame_function;
		logic       last;
	} rsp_beat_t;

	typedef struct packed {
		logic        hdr;
		logic [2:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic [7:0]  funit;
		logic [7:0]  ffunc;
		logic [15:0] trans;
		logic [7:0]  len;
		logic [7:0]  tx_unit;
		logic [7:0]  tx_func;
	} cmd_t;

endpackage

/* sv/mbap_front.sv */
// Front end: accepts items, runs the MBAP receive parser and transmit bookkeeping.
// Emits one queue entry per result or per transmit header burst.
// Depends on mbap_pkg.
module mbap_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  mbap_pkg::req_beat_t req,
	output logic               push,
	output mbap_pkg::cmd_t     cmd
);

	logic [3:0]  cnt_q, cnt_d;
	logic [15:0] pend_q, pend_d;
	logic [15:0] proto_q, proto_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  unit_q, unit_d;
	logic [7:0]  func_q, func_d;
	logic [15:0] reply_q, reply_d;
	logic [7:0]  txleft_q, txleft_d;
	logic [15:0] left_m2, left_m1;
	logic [7:0]  size_sat;
	logic [7:0]  b;

	assign b        = req.data_byte;
	assign left_m2  = left_q - 16'd2;
	assign left_m1  = left_q - 16'd1;
	assign size_sat = (req.payload_size > mbap_pkg::MAX_TX_PAYLOAD) ?
		mbap_pkg::MAX_TX_PAYLOAD : req.payload_size;

	always_comb begin
		cnt_d    = cnt_q;
		pend_d   = pend_q;
		proto_d  = proto_q;
		left_d   = left_q;
		unit_d   = unit_q;
		func_d   = func_q;
		reply_d  = reply_q;
		txleft_d = txleft_q;
		push     = 1'b0;
		cmd      = '0;
		cmd.funit = unit_q;
		cmd.ffunc = func_q;
		if (accept) begin
			case (req.operation)
				mbap_pkg::OP_RX_BYTE: begin
					case (cnt_q)
						4'd0: begin pend_d  = {b, 8'h00};        cnt_d = cnt_q + 4'd1; end
						4'd1: begin pend_d  = {pend_q[15:8], b}; cnt_d = cnt_q + 4'd1; end
						4'd2: begin proto_d = {b, 8'h00};        cnt_d = cnt_q + 4'd1; end
						4'd3: begin proto_d = {proto_q[15:8], b}; cnt_d = cnt_q + 4'd1; end
						4'd4: begin left_d  = {b, 8'h00};        cnt_d = cnt_q + 4'd1; end
						4'd5: begin left_d  = {left_q[15:8], b}; cnt_d = cnt_q + 4'd1; end
						4'd6: begin unit_d  = b;                 cnt_d = cnt_q + 4'd1; end
						4'd7: begin
							func_d    = b;
							cnt_d     = 4'd0;
							push      = 1'b1;
							cmd.ffunc = b;
							if (proto_q != 16'd0) begin
								cmd.kind = mbap_pkg::KIND_BAD_PROTO;
							end else if (left_q < 16'd2) begin
								cmd.kind = mbap_pkg::KIND_BAD_LENGTH;
							end else begin
								left_d   = left_m2;
								cmd.kind = mbap_pkg::KIND_RX_START;
								if (left_m2 == 16'd0) begin
									reply_d  = pend_q;
									cmd.last = 1'b1;
								end else begin
									cnt_d = mbap_pkg::HDR_BYTES;
								end
							end
						end
						default: begin
							left_d   = left_m1;
							push     = 1'b1;
							cmd.kind = mbap_pkg::KIND_RX_PAYLOAD;
							cmd.data = b;
							if (left_m1 == 16'd0) begin
								cnt_d    = 4'd0;
								reply_d  = pend_q;
								cmd.last = 1'b1;
							end
						end
					endcase
				end
				mbap_pkg::OP_TX_START: begin
					txleft_d    = size_sat;
					push        = 1'b1;
					cmd.hdr     = 1'b1;
					cmd.kind    = mbap_pkg::KIND_TX_BYTE;
					cmd.trans   = reply_q;
					cmd.len     = size_sat + 8'd2;
					cmd.tx_unit = req.unit_id;
					cmd.tx_func = req.function_code;
					cmd.last    = (size_sat == 8'd0);
				end
				mbap_pkg::OP_TX_BYTE: begin
					if (txleft_q != 8'd0) begin
						txleft_d = txleft_q - 8'd1;
						push     = 1'b1;
						cmd.kind = mbap_pkg::KIND_TX_BYTE;
						cmd.data = b;
						cmd.last = (txleft_q == 8'd1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pend_q   <= '0;
			proto_q  <= '0;
			left_q   <= '0;
			unit_q   <= '0;
			func_q   <= '0;
			reply_q  <= '0;
			txleft_q <= '0;
		end else begin
			cnt_q    <= cnt_d;
			pend_q   <= pend_d;
			proto_q  <= proto_d;
			left_q   <= left_d;
			unit_q   <= unit_d;
			func_q   <= func_d;
			reply_q  <= reply_d;
			txleft_q <= txleft_d;
		end
	end

endmodule

/* sv/mbap_queue.sv */
// Short queue of work entries between front end and back end.
// Register array with combinational head read; full drives the input stall.
// Depends on mbap_pkg.
module mbap_queue #(
	parameter int DEPTH = mbap_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbap_pkg::cmd_t push_data,
	input  logic           pop,
	output mbap_pkg::cmd_t head,
	output logic           full,
	output logic           not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mbap_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count missed a write");

endmodule

/* sv/mbap_back.sv */
// Back end: drains queue entries into the result register.
// Expands a transmit header entry into eight beats; other entries give one beat.
// Depends on mbap_pkg.
module mbap_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                not_empty,
	input  mbap_pkg::cmd_t      head,
	output logic                pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mbap_pkg::rsp_beat_t rsp_beat
);

	mbap_pkg::cmd_t      cur_q;
	logic                cur_valid_q;
	logic [2:0]          beat_q;
	mbap_pkg::rsp_beat_t out_q;
	logic                out_valid_q;
	logic                slot_free;
	logic                take;
	logic                cur_done;
	mbap_pkg::rsp_beat_t nxt;

	assign slot_free = !out_valid_q || !rsp_stall;
	assign take      = cur_valid_q && slot_free;
	assign cur_done  = !cur_q.hdr || (beat_q == mbap_pkg::TX_HDR_LAST);
	assign pop       = not_empty && (!cur_valid_q || (take && cur_done));
	assign rsp_valid = out_valid_q;
	assign rsp_beat  = out_q;

	always_comb begin
		nxt.kind           = cur_q.kind;
		nxt.frame_unit     = cur_q.funit;
		nxt.frame_function = cur_q.ffunc;
		nxt.out_byte       = cur_q.data;
		nxt.last           = cur_q.last;
		if (cur_q.hdr) begin
			nxt.last = 1'b0;
			case (beat_q)
				3'd0: nxt.out_byte = cur_q.trans[15:8];
				3'd1: nxt.out_byte = cur_q.trans[7:0];
				3'd5: nxt.out_byte = cur_q.len;
				3'd6: nxt.out_byte = cur_q.tx_unit;
				3'd7: begin
					nxt.out_byte = cur_q.tx_func;
					nxt.last     = cur_q.last;
				end
				default: nxt.out_byte = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (take) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (take && cur_done) begin
				cur_valid_q <= 1'b0;
			end
			if (take) begin
				beat_q <= cur_done ? 3'd0 : beat_q + 3'd1;
			end
			if (slot_free) begin
				out_valid_q <= cur_valid_q;
			end
		end
	end

endmodule

/* sv/mbap_frame_codec.sv */
// Top level of the Modbus TCP MBAP frame codec.
// Ties front end, work queue and back end; depends on mbap_pkg.
//
//   channel | direction | payload     | handshake
//   req     | in        | req_beat_t  | req_valid / req_stall
//   rsp     | out       | rsp_beat_t  | rsp_valid / rsp_stall
//
// A beat is taken each cycle while the queue has room; a received byte yields
// at most one result beat, which the back end registers into its result register.
// A transmit start yields eight result beats, one per cycle from the back end while rsp_stall is low.
// req_stall rises only when the QUEUE_DEPTH-entry queue is full.
// Reset clears parser state, transaction id, queue and result valid flag; result data is not reset.
module mbap_frame_codec #(
	parameter int QUEUE_DEPTH = mbap_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mbap_pkg::req_beat_t req_beat,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mbap_pkg::rsp_beat_t rsp_beat
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           full;
	logic           not_empty;
	mbap_pkg::cmd_t cmd;
	mbap_pkg::cmd_t head;

	assign req_stall = full;
	assign accept    = req_valid && !full;

	mbap_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req_beat),
		.push   (push),
		.cmd    (cmd)
	);

	mbap_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.not_empty (not_empty)
	);

	mbap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat)
	);

endmodule
